[sv/swhc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the sliding window hit counter
// no dependencies; every other file takes names from here by scope

package swhc_pkg;

  localparam int unsigned DefWindowLen = 256;
  localparam int unsigned StampW       = 31;
  localparam int unsigned CountW       = 32;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic CmdHit   = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [CountW-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StMod,
    StHitRd,
    StHitWr,
    StScan,
    StScanEnd,
    StEmit
  } state_e;

endpackage

[sv/swhc_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for commands and results
// depends on swhc_pkg for field widths

interface swhc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [swhc_pkg::StampW-1:0]  timestamp;

  modport source (output valid, output command, output timestamp, input ready);
  modport sink   (input valid, input command, input timestamp, output ready);
endinterface

interface swhc_res_if;
  logic                         valid;
  logic                         ready;
  logic [swhc_pkg::CountW-1:0]  hit_total;

  modport source (output valid, output hit_total, input ready);
  modport sink   (input valid, input hit_total, output ready);
endinterface

[sv/sliding_window_hit_counter.sv]
`timescale 1ns / 1ps
// Sliding window hit counter, top level.
// Commands arrive on cmd_i (command, timestamp); query answers leave on res_o
// (hit_total). A hit (command 0) records one event in the bucket picked by
// timestamp mod WINDOW_LEN and returns nothing. A query (command 1) returns the
// saturating sum of all buckets stamped less than WINDOW_LEN seconds before the
// query time, or after it.
// Command flow: a hit passes from its transfer through the multiply and remainder
// stages of the slot reduction by reciprocal multiplication, a hand-over of the
// slot, a read and a write of the bucket memory, and back to the idle state,
// which takes the next command.
// A query has the memory read port scan one bucket per cycle, then the sum is
// registered onto res_o. cmd_i.ready is high only while the block is idle;
// one item is worked on at a time.
// Reset: after rst_ni is released a clearing pass writes every bucket to zero,
// with cmd_i.ready held low.
// Stalls: the result register holds its answer until res_o.ready; new commands
// are still taken meanwhile, and a later query waits in its final state until
// the register is free.

module sliding_window_hit_counter #(
  parameter int unsigned WINDOW_LEN = swhc_pkg::DefWindowLen
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  swhc_cmd_if.sink       cmd_i,
  swhc_res_if.source     res_o
);

  localparam int unsigned IdxW = $clog2(WINDOW_LEN);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW_LEN - 1);
  localparam logic [swhc_pkg::CountW-1:0] WinAge = swhc_pkg::CountW'(WINDOW_LEN);

  swhc_pkg::state_e state_q, state_d;

  logic [IdxW-1:0]               idx_q, idx_d;
  logic [swhc_pkg::StampW-1:0]   ts_q, ts_d;
  logic [swhc_pkg::CountW-1:0]   acc_q, acc_d;
  logic                          scan_pend_q;
  logic                          out_valid_q, out_valid_d;
  logic [swhc_pkg::CountW-1:0]   total_q, total_d;

  logic                          cmd_xfer;
  logic                          out_free;
  logic                          idx_last;

  logic                          mod_busy;
  logic [IdxW-1:0]               slot;

  logic                          ram_we;
  logic [IdxW-1:0]               ram_waddr;
  swhc_pkg::entry_t              ram_wdata;
  logic                          ram_re;
  logic [IdxW-1:0]               ram_raddr;
  swhc_pkg::entry_t              ram_rdata;
  swhc_pkg::entry_t              hit_entry;

  logic [swhc_pkg::CountW-1:0]   age;
  logic                          in_window;
  logic [swhc_pkg::CountW:0]     sum_wide;

  assign cmd_xfer = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign idx_last = (idx_q == LastIdx);

  swhc_slot_mod #(
    .WindowLen (WINDOW_LEN)
  ) u_slot_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_xfer && (cmd_i.command == swhc_pkg::CmdHit)),
    .dividend_i (cmd_i.timestamp),
    .busy_o     (mod_busy),
    .rem_o      (slot)
  );

  swhc_bucket_ram #(
    .Depth (WINDOW_LEN)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swhc_pkg::StClear: begin
        if (idx_last) state_d = swhc_pkg::StIdle;
      end
      swhc_pkg::StIdle: begin
        if (cmd_xfer) begin
          state_d = (cmd_i.command == swhc_pkg::CmdQuery) ? swhc_pkg::StScan
                                                          : swhc_pkg::StMod;
        end
      end
      swhc_pkg::StMod: begin
        if (!mod_busy) state_d = swhc_pkg::StHitRd;
      end
      swhc_pkg::StHitRd:   state_d = swhc_pkg::StHitWr;
      swhc_pkg::StHitWr:   state_d = swhc_pkg::StIdle;
      swhc_pkg::StScan: begin
        if (idx_last) state_d = swhc_pkg::StScanEnd;
      end
      swhc_pkg::StScanEnd: state_d = swhc_pkg::StEmit;
      swhc_pkg::StEmit: begin
        if (out_free) state_d = swhc_pkg::StIdle;
      end
      default:             state_d = swhc_pkg::StClear;
    endcase
  end

  // read-modify-write of the hit bucket
  always_comb begin
    hit_entry = ram_rdata;
    if (ram_rdata.stamp != ts_q) begin
      hit_entry.stamp = ts_q;
      hit_entry.count = swhc_pkg::CountW'(1);
    end else if (ram_rdata.count != swhc_pkg::CountMax) begin
      hit_entry.count = ram_rdata.count + 1'b1;
    end
  end

  // window test: a stamp later than the query time counts as well
  assign age       = {1'b0, ts_q} - {1'b0, ram_rdata.stamp};
  assign in_window = age[swhc_pkg::CountW-1] || (age < WinAge);
  assign sum_wide  = {1'b0, acc_q} + {1'b0, ram_rdata.count};

  // outputs and datapath
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    idx_d       = idx_q;
    ts_d        = ts_q;
    acc_d       = acc_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !res_o.ready;
    cmd_i.ready = 1'b0;

    if (scan_pend_q && in_window) begin
      acc_d = sum_wide[swhc_pkg::CountW] ? swhc_pkg::CountMax
                                         : sum_wide[swhc_pkg::CountW-1:0];
    end

    case (state_q)
      swhc_pkg::StClear: begin
        ram_we = 1'b1;
        idx_d  = idx_q + 1'b1;
      end
      swhc_pkg::StIdle: begin
        cmd_i.ready = 1'b1;
        if (cmd_xfer) begin
          ts_d  = cmd_i.timestamp;
          idx_d = '0;
          acc_d = '0;
        end
      end
      swhc_pkg::StMod: begin
      end
      swhc_pkg::StHitRd: begin
        ram_re    = 1'b1;
        ram_raddr = slot;
      end
      swhc_pkg::StHitWr: begin
        ram_we    = 1'b1;
        ram_waddr = slot;
        ram_wdata = hit_entry;
      end
      swhc_pkg::StScan: begin
        ram_re = 1'b1;
        idx_d  = idx_q + 1'b1;
      end
      swhc_pkg::StScanEnd: begin
      end
      swhc_pkg::StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          total_d     = acc_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swhc_pkg::StClear;
      idx_q       <= '0;
      scan_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      scan_pend_q <= (state_q == swhc_pkg::StScan);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q    <= ts_d;
    acc_q   <= acc_d;
    total_q <= total_d;
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.hit_total = total_q;

endmodule

[sv/swhc_bucket_ram.sv]
`timescale 1ns / 1ps
// bucket store: one write port, one read port, registered read data
// depends on swhc_pkg for the entry layout

module swhc_bucket_ram #(
  parameter int unsigned Depth = swhc_pkg::DefWindowLen,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  swhc_pkg::entry_t     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output swhc_pkg::entry_t     rdata_o
);

  swhc_pkg::entry_t mem [Depth];
  swhc_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/swhc_slot_mod.sv]
`timescale 1ns / 1ps
// reduction of a timestamp modulo the window length in two registered stages
// depends on swhc_pkg for the stamp width

module swhc_slot_mod #(
  parameter int unsigned WindowLen = swhc_pkg::DefWindowLen,
  localparam int unsigned IdxW = $clog2(WindowLen)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [swhc_pkg::StampW-1:0]  dividend_i,
  output logic                         busy_o,
  output logic [IdxW-1:0]              rem_o
);

  // quotient by reciprocal multiplication, exact for every stamp value
  localparam int unsigned Shift  = swhc_pkg::StampW + IdxW;
  localparam int unsigned RecipW = swhc_pkg::StampW + 1;
  localparam int unsigned ProdW  = swhc_pkg::StampW + RecipW;
  localparam int unsigned QuotW  = ProdW - Shift;
  localparam logic [63:0] RecipWide =
    ((64'd1 << Shift) + 64'(WindowLen) - 64'd1) / 64'(WindowLen);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipWide);
  localparam logic [swhc_pkg::StampW-1:0] WinStamp = swhc_pkg::StampW'(WindowLen);

  localparam logic [1:0] StageNone = 2'd0;
  localparam logic [1:0] StageRem  = 2'd1;
  localparam logic [1:0] StageMul  = 2'd2;

  logic [swhc_pkg::StampW-1:0]  div_q, div_d;
  logic [QuotW-1:0]             quot_q, quot_d;
  logic [IdxW-1:0]              rem_q, rem_d;
  logic [1:0]                   stage_q, stage_d;
  logic [ProdW-1:0]             prod;
  logic [swhc_pkg::StampW-1:0]  back;
  logic [swhc_pkg::StampW-1:0]  rem_full;

  assign prod     = ProdW'(div_q) * ProdW'(Recip);
  assign back     = swhc_pkg::StampW'(quot_q) * WinStamp;
  assign rem_full = div_q - back;

  always_comb begin
    div_d   = div_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    stage_d = stage_q;
    if (start_i) begin
      div_d   = dividend_i;
      stage_d = StageMul;
    end else begin
      case (stage_q)
        StageMul: begin
          quot_d  = prod[ProdW-1:Shift];
          stage_d = StageRem;
        end
        StageRem: begin
          // remainder is below the window, so the low bits hold all of it
          rem_d   = rem_full[IdxW-1:0];
          stage_d = StageNone;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= StageNone;
    end else begin
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = (stage_q != StageNone);
  assign rem_o  = rem_q;

endmodule

[sv/swhc_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the sliding window hit counter, bound to the top level
// depends on swhc_pkg for field widths

module swhc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [swhc_pkg::CountW-1:0]  hit_total_i
);

  // a waiting result stays until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(hit_total_i))
    else $error("stalled result changed");

  // every command keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while previous one still in work");

  // a new result only follows a busy cycle of the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while block was idle");

endmodule

bind sliding_window_hit_counter swhc_checker u_swhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .hit_total_i (res_o.hit_total)
);

[verif/sliding_window_hit_counter_tb.sv]
`timescale 1ns / 1ps
// testbench for sliding_window_hit_counter: hits and queries against a bucket-ring predictor
// depends on swhc_pkg, swhc_if (command and result channels) and the top level

class window_total_tracker;
  localparam int unsigned Window = swhc_pkg::DefWindowLen;

  logic [swhc_pkg::StampW-1:0] slot_stamp [Window];
  logic [swhc_pkg::CountW-1:0] slot_count [Window];
  logic [swhc_pkg::CountW-1:0] expected_totals [$];
  int unsigned faults;

  function new();
    foreach (slot_stamp[i]) begin
      slot_stamp[i] = '0;
      slot_count[i] = '0;
    end
    faults = 0;
  endfunction

  function logic [swhc_pkg::CountW-1:0] window_total(logic [swhc_pkg::StampW-1:0] ts);
    longint unsigned total;
    longint age;
    total = 0;
    for (int i = 0; i < Window; i++) begin
      // signed age, so buckets stamped after the query time still count
      age = longint'({1'b0, ts}) - longint'({1'b0, slot_stamp[i]});
      if (age < longint'(Window)) begin
        total += longint'(slot_count[i]);
        if (total > longint'(swhc_pkg::CountMax)) total = longint'(swhc_pkg::CountMax);
      end
    end
    return total[swhc_pkg::CountW-1:0];
  endfunction

  // called for every accepted command transfer
  function void log_command(logic cmd, logic [swhc_pkg::StampW-1:0] ts);
    int unsigned slot;
    slot = ts % Window;
    if (cmd == swhc_pkg::CmdQuery) begin
      expected_totals.insert(expected_totals.size(), window_total(ts));
    end else if (slot_stamp[slot] != ts) begin
      slot_stamp[slot] = ts;
      slot_count[slot] = 1;
    end else if (slot_count[slot] != swhc_pkg::CountMax) begin
      slot_count[slot] = slot_count[slot] + 1;
    end
  endfunction

  function void report_fault(string msg);
    faults++;
    if (faults <= 10) $display("mismatch: %s", msg);
  endfunction

  // called for every accepted result transfer
  function void check_total(logic [swhc_pkg::CountW-1:0] got);
    logic [swhc_pkg::CountW-1:0] want;
    if (expected_totals.size() == 0) begin
      report_fault($sformatf("hit_total %0d with no query outstanding", got));
      return;
    end
    want = expected_totals[0];
    expected_totals.delete(0);
    if (got !== want)
      report_fault($sformatf("hit_total expected %0d actual %0d", want, got));
  endfunction

  function int unsigned outstanding();
    return expected_totals.size();
  endfunction
endclass

module sliding_window_hit_counter_tb;

  localparam int unsigned WindowLen  = swhc_pkg::DefWindowLen;
  localparam int unsigned CycleLimit = 10_000_000;
  localparam logic [swhc_pkg::StampW-1:0] StampMax = '1;

  logic clk_i;
  logic rst_ni;

  swhc_cmd_if cmd_if ();
  swhc_res_if res_if ();

  sliding_window_hit_counter #(
    .WINDOW_LEN (WindowLen)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  window_total_tracker tracker = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned stall_left;
  int unsigned cycle_count;
  longint      now_sec;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL sliding_window_hit_counter");
      $finish;
    end
  end

  // result side: short random stalls plus the odd long one, so the result
  // register is held while further commands go in
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else if (recv_stall_pct != 0 && $urandom_range(0, 499) == 0) begin
      res_if.ready <= 1'b0;
      stall_left = $urandom_range(40, 400) - 1;
    end else if ($urandom_range(0, 99) < recv_stall_pct) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) tracker.check_total(res_if.hit_total);
  end

  task automatic send_item(input logic cmd, input logic [swhc_pkg::StampW-1:0] ts);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= cmd;
    cmd_if.timestamp <= ts;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    tracker.log_command(cmd, ts);
  endtask

  // mostly forward time with bursts in the same second, some window-sized
  // jumps, occasional steps back and fresh epochs anywhere in the range
  task automatic random_phase(input int unsigned count, input int unsigned idle_pct,
                              input int unsigned stall_pct);
    int unsigned roll;
    logic cmd;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      roll = $urandom_range(0, 999);
      if (roll < 5) now_sec = $urandom() & StampMax;
      else if (roll < 8) now_sec = longint'(StampMax) - $urandom_range(0, 600);
      else if (roll < 30) now_sec = now_sec - $urandom_range(1, 300);
      else if (roll < 80) now_sec = now_sec + $urandom_range(200, 600);
      else if (roll < 400) now_sec = now_sec + $urandom_range(1, 4);
      if (now_sec < 0) now_sec = 0;
      if (now_sec > longint'(StampMax)) now_sec = longint'(StampMax);
      cmd = ($urandom_range(0, 3) == 0) ? swhc_pkg::CmdQuery : swhc_pkg::CmdHit;
      send_item(cmd, now_sec[swhc_pkg::StampW-1:0]);
    end
  endtask

  initial begin
    cycle_count      = 0;
    stall_left       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    now_sec          = 0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = swhc_pkg::CmdHit;
    cmd_if.timestamp = '0;
    res_if.ready     = 1'b0;
    rst_ni           = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty window, then fresh buckets at time zero
    send_item(swhc_pkg::CmdQuery, '0);
    send_item(swhc_pkg::CmdHit, '0);
    send_item(swhc_pkg::CmdHit, '0);
    send_item(swhc_pkg::CmdQuery, '0);
    // last slot of the ring, and the edge where time zero falls out
    send_item(swhc_pkg::CmdHit, 31'd255);
    send_item(swhc_pkg::CmdQuery, 31'd255);
    send_item(swhc_pkg::CmdQuery, 31'd256);
    send_item(swhc_pkg::CmdHit, 31'd256);
    send_item(swhc_pkg::CmdHit, 31'd256);
    send_item(swhc_pkg::CmdQuery, 31'd511);
    send_item(swhc_pkg::CmdQuery, 31'd512);
    // top of the stamp range
    send_item(swhc_pkg::CmdHit, StampMax);
    send_item(swhc_pkg::CmdHit, StampMax);
    send_item(swhc_pkg::CmdQuery, StampMax);
    // time going backwards: later stamps still count, older hit restamps
    send_item(swhc_pkg::CmdQuery, 31'd100);
    send_item(swhc_pkg::CmdHit, 31'd5);
    send_item(swhc_pkg::CmdQuery, 31'd5);
    send_item(swhc_pkg::CmdHit, StampMax - 31'd255);
    send_item(swhc_pkg::CmdQuery, StampMax - 31'd255);
    send_item(swhc_pkg::CmdQuery, 31'h4000_0000);

    now_sec = 1000;
    random_phase(465, 0, 0);
    random_phase(462, 54, 0);
    random_phase(462, 0, 54);
    random_phase(462, 38, 38);

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    recv_stall_pct = 0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    // a trailing hit may still be in its read-modify-write
    repeat (WindowLen + 8) @(posedge clk_i);

    if (tracker.faults == 0 && tracker.outstanding() == 0) begin
      $display("PASS sliding_window_hit_counter");
    end else begin
      $display("FAIL sliding_window_hit_counter");
    end
    $finish;
  end
endmodule
